### rtl/core/pqdo_pkg.sv
package pqdo_pkg;

  // Field widths fixed by the channel definitions.
  localparam int unsigned PAYLOAD_W   = 32;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned PRIO_W      = 2;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned CAP_LIMIT   = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Level index wide enough for the largest supported number of levels.
  localparam int unsigned LEVEL_IDX_W = 3;

  // Request codes.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [PRIO_W-1:0]    priority_req;
    logic [PAYLOAD_W-1:0] item_payload;
  } req_t;

  typedef struct packed {
    logic                 accepted;
    logic [PRIO_W-1:0]    out_priority;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [STAMP_W-1:0]   out_sequence;
    logic                 dropped;
    logic [PRIO_W-1:0]    dropped_priority;
    logic [PAYLOAD_W-1:0] dropped_payload;
    logic [CAP_W-1:0]     item_count;
    logic                 is_empty;
    logic                 is_full;
  } rsp_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
  } cfg_t;

  // Result of the head arbitration across levels.
  typedef struct packed {
    logic                   pop_found;
    logic [LEVEL_IDX_W-1:0] pop_lv;
    logic                   drop_found;
    logic [LEVEL_IDX_W-1:0] drop_lv;
  } sel_t;

endpackage

### rtl/core/pqdo_chan_if.sv
interface pqdo_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/priority_queue_drop_oldest.sv
// Strict-priority queue of NUM_PRIO FIFO levels sharing one total capacity.
// req_i carries one request per beat: a push with its level and payload, or a
// pop. rsp_o returns exactly one result beat per request, in request order,
// with the popped or dropped item, the item count and the empty/full flags.
// cfg_i writes the capacity register; it is always ready and is meant to be
// written only while no request is in flight.
// A request accepted on req_i is registered in req_q and passes through S_READ,
// which reads the level heads from the per-level RAMs (registered read), then
// S_EXEC, which arbitrates, updates pointers and counts and loads the output
// register. A new request is taken in S_EXEC as that step completes, so the
// block does not take a new request while the previous one is in S_READ.
// A held result does not block the next request from entering; that request
// waits in its arbitration cycle only until the output register frees up.
// Reset clears all pointers, counts, the stamp counter and the output
// valid, and sets the capacity to 16. RAM contents are not cleared; an entry
// is only read after it has been written.
module priority_queue_drop_oldest #(
  parameter int unsigned NUM_PRIO    = 3,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pqdo_chan_if.sink           req_i,
  pqdo_chan_if.source         rsp_o,
  pqdo_chan_if.sink           cfg_i
);

  localparam int unsigned DW     = (DATA_WIDTH < pqdo_pkg::PAYLOAD_W) ? DATA_WIDTH
                                                                      : pqdo_pkg::PAYLOAD_W;
  localparam int unsigned WORD_W = DW + pqdo_pkg::STAMP_W;
  localparam int unsigned PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int unsigned FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned LV_W   = $clog2(NUM_PRIO);
  localparam int unsigned CW     = pqdo_pkg::CAP_W;
  localparam int unsigned CAP_LIM = (NUM_PRIO * LEVEL_DEPTH < pqdo_pkg::CAP_LIMIT) ?
                                    NUM_PRIO * LEVEL_DEPTH : pqdo_pkg::CAP_LIMIT;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]                  state_q, state_d;
  pqdo_pkg::req_t              req_q;
  logic [CW-1:0]               cap_q;
  logic [NUM_PRIO-1:0][PTR_W-1:0]  head_q, tail_q;
  logic [NUM_PRIO-1:0][FILL_W-1:0] fill_q;
  logic [CW-1:0]               count_q, count_d;
  logic [pqdo_pkg::STAMP_W-1:0] stamp_q;
  logic                        rsp_valid_q;
  pqdo_pkg::rsp_t              rsp_q, rsp_d;

  logic                        req_fire, out_free, exec_done;
  logic [CW-1:0]               cap_eff;
  logic [NUM_PRIO-1:0][WORD_W-1:0] head_word;
  logic [NUM_PRIO-1:0][pqdo_pkg::STAMP_W-1:0] head_stamp;
  logic [NUM_PRIO-1:0]         nonempty;
  pqdo_pkg::sel_t              sel;

  logic                        is_push, prio_ok, at_cap, do_drop, do_pop, do_store;
  logic [LV_W-1:0]             push_lv, drop_lv, pop_lv;
  logic [FILL_W-1:0]           fill_after;
  logic [NUM_PRIO-1:0]         take_lv, put_lv;
  logic [DW-1:0]               drop_data, pop_data;
  logic [pqdo_pkg::STAMP_W-1:0] pop_stamp;

  // Handshakes and sequencing.
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign exec_done   = (state_q == S_EXEC) && out_free;
  assign req_i.ready = (state_q == S_IDLE) || exec_done;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_fire) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        if (req_fire) begin
          state_d = S_READ;
        end else if (exec_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Effective capacity: zero acts as one, and the top is clamped.
  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (cap_q > CW'(CAP_LIM)) begin
      cap_eff = CW'(CAP_LIM);
    end
  end

  // One RAM per level, always reading at that level's head.
  for (genvar lv = 0; lv < NUM_PRIO; lv++) begin : g_level
    pqdo_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LEVEL_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (exec_done && put_lv[lv]),
      .waddr_i (tail_q[lv]),
      .wdata_i ({stamp_q, req_q.item_payload[DW-1:0]}),
      .raddr_i (head_q[lv]),
      .rdata_o (head_word[lv])
    );
    assign head_stamp[lv] = head_word[lv][DW +: pqdo_pkg::STAMP_W];
    assign nonempty[lv]   = (fill_q[lv] != '0);
  end

  pqdo_select #(
    .NUM_PRIO (NUM_PRIO)
  ) u_select (
    .nonempty_i   (nonempty),
    .head_stamp_i (head_stamp),
    .stamp_ref_i  (stamp_q + pqdo_pkg::STAMP_W'(1)),
    .sel_o        (sel)
  );

  // Decide what this request does to the levels.
  always_comb begin
    is_push  = (req_q.req_type == pqdo_pkg::REQ_PUSH);
    prio_ok  = (int'(req_q.priority_req) < NUM_PRIO);
    push_lv  = LV_W'(req_q.priority_req);
    drop_lv  = LV_W'(sel.drop_lv);
    pop_lv   = LV_W'(sel.pop_lv);
    at_cap   = (count_q >= cap_eff);
    do_drop  = is_push && prio_ok && at_cap && sel.drop_found;
    do_pop   = !is_push && sel.pop_found;
    fill_after = '0;
    if (prio_ok) begin
      fill_after = fill_q[push_lv] - FILL_W'(do_drop && (drop_lv == push_lv));
    end
    do_store = is_push && prio_ok && (fill_after < FILL_W'(LEVEL_DEPTH));
    for (int lv = 0; lv < NUM_PRIO; lv++) begin
      take_lv[lv] = (do_drop && (drop_lv == LV_W'(lv))) || (do_pop && (pop_lv == LV_W'(lv)));
      put_lv[lv]  = do_store && (push_lv == LV_W'(lv));
    end
    drop_data = head_word[drop_lv][DW-1:0];
    pop_data  = head_word[pop_lv][DW-1:0];
    pop_stamp = head_stamp[pop_lv];
    count_d   = count_q + CW'(do_store) - CW'(do_drop || do_pop);
  end

  // Result beat.
  always_comb begin
    rsp_d                  = '0;
    rsp_d.accepted         = do_store || do_pop;
    if (do_pop) begin
      rsp_d.out_priority   = pqdo_pkg::PRIO_W'(pop_lv);
      rsp_d.out_payload    = pqdo_pkg::PAYLOAD_W'(pop_data);
      rsp_d.out_sequence   = pop_stamp;
    end
    if (do_drop) begin
      rsp_d.dropped          = 1'b1;
      rsp_d.dropped_priority = pqdo_pkg::PRIO_W'(drop_lv);
      rsp_d.dropped_payload  = pqdo_pkg::PAYLOAD_W'(drop_data);
    end
    rsp_d.item_count       = count_d;
    rsp_d.is_empty         = (count_d == '0);
    rsp_d.is_full          = (count_d >= cap_eff);
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= pqdo_pkg::CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      stamp_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.data.capacity;
      end
      if (exec_done) begin
        for (int lv = 0; lv < NUM_PRIO; lv++) begin
          if (take_lv[lv]) begin
            head_q[lv] <= (head_q[lv] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                  : head_q[lv] + PTR_W'(1);
          end
          if (put_lv[lv]) begin
            tail_q[lv] <= (tail_q[lv] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                  : tail_q[lv] + PTR_W'(1);
          end
          fill_q[lv] <= fill_q[lv] + FILL_W'(put_lv[lv]) - FILL_W'(take_lv[lv]);
        end
        count_q <= count_d;
        if (is_push && prio_ok) begin
          stamp_q <= stamp_q + pqdo_pkg::STAMP_W'(1);
        end
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_q <= req_i.data;
    end
    if (exec_done) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

### rtl/core/pqdo_ram.sv
module pqdo_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pqdo_select.sv
module pqdo_select #(
  parameter int unsigned NUM_PRIO = 3
) (
  input  logic [NUM_PRIO-1:0]                        nonempty_i,
  input  logic [NUM_PRIO-1:0][pqdo_pkg::STAMP_W-1:0] head_stamp_i,
  input  logic [pqdo_pkg::STAMP_W-1:0]               stamp_ref_i,
  output pqdo_pkg::sel_t                             sel_o
);

  logic [NUM_PRIO-1:0][pqdo_pkg::STAMP_W-1:0] age;

  // Age of each head relative to the advanced counter, modulo the stamp width.
  always_comb begin
    for (int lv = 0; lv < NUM_PRIO; lv++) begin
      age[lv] = stamp_ref_i - head_stamp_i[lv];
    end
  end

  // Pop takes the lowest-numbered nonempty level; drop takes the oldest head,
  // with ties going to the lower-numbered level.
  always_comb begin
    logic [pqdo_pkg::STAMP_W-1:0] best_age;
    sel_o      = '0;
    best_age   = '0;
    for (int lv = NUM_PRIO - 1; lv >= 0; lv--) begin
      if (nonempty_i[lv]) begin
        sel_o.pop_found = 1'b1;
        sel_o.pop_lv    = pqdo_pkg::LEVEL_IDX_W'(lv);
      end
    end
    for (int lv = 0; lv < NUM_PRIO; lv++) begin
      if (nonempty_i[lv] && (!sel_o.drop_found || age[lv] > best_age)) begin
        sel_o.drop_found = 1'b1;
        sel_o.drop_lv    = pqdo_pkg::LEVEL_IDX_W'(lv);
        best_age         = age[lv];
      end
    end
  end

endmodule

### rtl/core/pqdo_checker.sv
module pqdo_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input pqdo_pkg::rsp_t rsp_data_i
);

  // A stalled result beat stays offered.
  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_rsp_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("result payload changed while stalled");

  // The empty flag agrees with the count.
  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_data_i.is_empty == (rsp_data_i.item_count == '0)))
    else $error("empty flag disagrees with item count");

  // A push that dropped and still stored leaves the queue at capacity.
  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.dropped && rsp_data_i.accepted |-> rsp_data_i.is_full)
    else $error("drop with store did not leave the queue full");

  // The count never passes the capacity ceiling.
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_data_i.item_count <= pqdo_pkg::CAP_W'(pqdo_pkg::CAP_LIMIT)))
    else $error("item count above capacity ceiling");

endmodule

bind priority_queue_drop_oldest pqdo_checker u_pqdo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

### test/priority_queue_drop_oldest_tb.sv
module priority_queue_drop_oldest_tb;

  localparam int unsigned PRIO_LEVELS   = 3;
  localparam int unsigned LEVEL_SLOTS   = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned IDLE_PERCENT  = 16;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_COUNT   = 10;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned CALM_PHASE    = 3;
  localparam logic [pqdo_pkg::PRIO_W-1:0] BAD_PRIO = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  pqdo_chan_if #(.T(pqdo_pkg::req_t)) req_if ();
  pqdo_chan_if #(.T(pqdo_pkg::rsp_t)) rsp_if ();
  pqdo_chan_if #(.T(pqdo_pkg::cfg_t)) cfg_if ();

  priority_queue_drop_oldest #(
    .NUM_PRIO    (PRIO_LEVELS),
    .LEVEL_DEPTH (LEVEL_SLOTS),
    .DATA_WIDTH  (WORD_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting for the driver and results waiting for the monitor.
  pqdo_pkg::req_t pending_reqs[$];
  pqdo_pkg::rsp_t expected_results[$];
  int unsigned    items_sent;
  int unsigned    results_checked;
  int unsigned    mismatch_count;
  bit             no_idle;

  // Shadow copy of the queue contents and control state.
  logic [pqdo_pkg::PAYLOAD_W-1:0] slot_data  [PRIO_LEVELS][LEVEL_SLOTS];
  logic [pqdo_pkg::STAMP_W-1:0]   slot_stamp [PRIO_LEVELS][LEVEL_SLOTS];
  int unsigned                    head_ptr   [PRIO_LEVELS];
  int unsigned                    tail_ptr   [PRIO_LEVELS];
  int unsigned                    fill_cnt   [PRIO_LEVELS];
  int unsigned                    total_held;
  logic [pqdo_pkg::STAMP_W-1:0]   next_stamp;
  logic [pqdo_pkg::CAP_W-1:0]     cap_reg;

  // A capacity of zero behaves as one; large values clamp to the storage limit.
  function automatic int unsigned effective_capacity();
    int unsigned lim;
    int unsigned cap;
    lim = pqdo_pkg::CAP_LIMIT;
    if (PRIO_LEVELS * LEVEL_SLOTS < lim) lim = PRIO_LEVELS * LEVEL_SLOTS;
    cap = 32'(cap_reg);
    if (cap == 0) cap = 1;
    if (cap > lim) cap = lim;
    return cap;
  endfunction

  // Remove the head entry of one level.
  function automatic void take_head(int unsigned lv);
    head_ptr[lv] = (head_ptr[lv] + 1) % LEVEL_SLOTS;
    fill_cnt[lv]--;
    total_held--;
  endfunction

  // Apply one request to the shadow queue and return the result it produces.
  function automatic pqdo_pkg::rsp_t queue_step(pqdo_pkg::req_t r);
    pqdo_pkg::rsp_t               res;
    int unsigned                  cap;
    int unsigned                  oldest;
    int unsigned                  prio;
    bit                           found;
    logic [pqdo_pkg::STAMP_W-1:0] stamp;
    logic [pqdo_pkg::STAMP_W-1:0] age;
    logic [pqdo_pkg::STAMP_W-1:0] oldest_age;
    res = '0;
    cap = effective_capacity();
    prio = 32'(r.priority_req);
    found = 1'b0;
    oldest = 0;
    oldest_age = '0;
    if (r.req_type == pqdo_pkg::REQ_PUSH) begin
      if (prio < PRIO_LEVELS) begin
        stamp = next_stamp;
        next_stamp = next_stamp + pqdo_pkg::STAMP_W'(1);
        // At capacity, the head that lags the counter the most goes first.
        if (total_held >= cap) begin
          for (int unsigned lv = 0; lv < PRIO_LEVELS; lv++) begin
            if (fill_cnt[lv] != 0) begin
              age = next_stamp - slot_stamp[lv][head_ptr[lv]];
              if (!found || age > oldest_age) begin
                found = 1'b1;
                oldest = lv;
                oldest_age = age;
              end
            end
          end
          if (found) begin
            res.dropped = 1'b1;
            res.dropped_priority = pqdo_pkg::PRIO_W'(oldest);
            res.dropped_payload = slot_data[oldest][head_ptr[oldest]];
            take_head(oldest);
          end
        end
        // The stamp stays consumed even when the target level has no room.
        if (fill_cnt[prio] < LEVEL_SLOTS) begin
          slot_data[prio][tail_ptr[prio]] = r.item_payload;
          slot_stamp[prio][tail_ptr[prio]] = stamp;
          tail_ptr[prio] = (tail_ptr[prio] + 1) % LEVEL_SLOTS;
          fill_cnt[prio]++;
          total_held++;
          res.accepted = 1'b1;
        end
      end
    end else begin
      // Pop serves the lowest-numbered level that holds anything.
      for (int unsigned lv = 0; lv < PRIO_LEVELS; lv++) begin
        if (!found && fill_cnt[lv] != 0) begin
          found = 1'b1;
          res.accepted = 1'b1;
          res.out_priority = pqdo_pkg::PRIO_W'(lv);
          res.out_payload = slot_data[lv][head_ptr[lv]];
          res.out_sequence = slot_stamp[lv][head_ptr[lv]];
          take_head(lv);
        end
      end
    end
    res.item_count = pqdo_pkg::CAP_W'(total_held);
    res.is_empty = (total_held == 0);
    res.is_full = (total_held >= cap);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result %0d: %s expected %h, got %h", results_checked, name, want, got);
    end
  endtask

  task automatic queue_req(logic req, logic [pqdo_pkg::PRIO_W-1:0] prio,
                           logic [pqdo_pkg::PAYLOAD_W-1:0] payload);
    pqdo_pkg::req_t r;
    r.req_type = req;
    r.priority_req = prio;
    r.item_payload = payload;
    pending_reqs.push_back(r);
    items_sent++;
  endtask

  // Wait until every queued request has produced its checked result.
  task automatic wait_idle();
    while (results_checked != items_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The capacity port is written only while nothing is in flight.
  task automatic write_capacity(logic [pqdo_pkg::CAP_W-1:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= pqdo_pkg::cfg_t'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    cap_reg = value;
    cfg_if.valid <= 1'b0;
  endtask

  // Mixed traffic with a given share of pushes; a few pushes use a bad level.
  task automatic run_random_phase(int unsigned count, int unsigned push_pct);
    logic [pqdo_pkg::PRIO_W-1:0] prio;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < push_pct) begin
        prio = ($urandom_range(9) == 0) ? BAD_PRIO
                                        : pqdo_pkg::PRIO_W'($urandom_range(PRIO_LEVELS - 1));
        queue_req(pqdo_pkg::REQ_PUSH, prio, $urandom());
      end else begin
        queue_req(pqdo_pkg::REQ_POP, pqdo_pkg::PRIO_W'($urandom_range(3)), $urandom());
      end
    end
    wait_idle();
  endtask

  // Request driver: records each accepted beat and launches the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
    end else begin
      if (req_if.valid && req_if.ready) expected_results.push_back(queue_step(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
          req_if.valid <= 1'b1;
          req_if.data <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted beat with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    pqdo_pkg::rsp_t want;
    pqdo_pkg::rsp_t got;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) $display("result beat with no request pending");
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(got.accepted));
          check_field("out_priority", 32'(want.out_priority), 32'(got.out_priority));
          check_field("out_payload", want.out_payload, got.out_payload);
          check_field("out_sequence", want.out_sequence, got.out_sequence);
          check_field("dropped", 32'(want.dropped), 32'(got.dropped));
          check_field("dropped_priority", 32'(want.dropped_priority),
                      32'(got.dropped_priority));
          check_field("dropped_payload", want.dropped_payload, got.dropped_payload);
          check_field("item_count", 32'(want.item_count), 32'(got.item_count));
          check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(got.is_full));
          results_checked++;
        end
      end
      rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    logic [pqdo_pkg::CAP_W-1:0] phase_caps [PHASE_COUNT];
    int unsigned                phase_push [PHASE_COUNT];
    phase_caps = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd2, 5'd17, 5'd12, 5'd3};
    phase_push = '{70, 50, 80, 60, 55, 75, 40, 65, 85, 50};
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = pqdo_pkg::cfg_t'(pqdo_pkg::CAP_RESET);
    items_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    no_idle = 1'b0;
    for (int unsigned lv = 0; lv < PRIO_LEVELS; lv++) begin
      head_ptr[lv] = 0;
      tail_ptr[lv] = 0;
      fill_cnt[lv] = 0;
    end
    total_held = 0;
    next_stamp = '0;
    cap_reg = pqdo_pkg::CAP_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Pop from an empty queue, a push to a bad level, one item per level.
    queue_req(pqdo_pkg::REQ_POP, 2'd0, 32'h0000_0000);
    queue_req(pqdo_pkg::REQ_PUSH, BAD_PRIO, 32'hFFFF_FFFF);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd0, 32'h0000_0000);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd1, 32'hFFFF_FFFF);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd2, 32'hA5A5_A5A5);
    repeat (4) queue_req(pqdo_pkg::REQ_POP, 2'd3, 32'hFFFF_FFFF);
    wait_idle();

    // Zero capacity acts as one: every later push evicts the previous item.
    write_capacity(5'd0);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd2, 32'h0000_0001);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd1, 32'h0000_0002);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd0, 32'h0000_0003);
    queue_req(pqdo_pkg::REQ_POP, 2'd0, 32'h0000_0000);
    wait_idle();

    // Overflow across levels, then capacity lowered below the held count.
    write_capacity(5'd4);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd1, 32'h1111_1111);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd2, 32'h2222_2222);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd0, 32'h3333_3333);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd1, 32'h4444_4444);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd2, 32'h5555_5555);
    wait_idle();
    write_capacity(5'd2);
    queue_req(pqdo_pkg::REQ_PUSH, 2'd0, 32'h6666_6666);
    queue_req(pqdo_pkg::REQ_POP, 2'd1, 32'h0000_0000);
    wait_idle();

    // Random traffic under a series of capacities, one phase without stalls.
    for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
      write_capacity(phase_caps[ph]);
      no_idle = (ph == CALM_PHASE);
      run_random_phase(PHASE_ITEMS, phase_push[ph]);
    end
    no_idle = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### priority_queue_drop_oldest.f
rtl/core/pqdo_pkg.sv
rtl/core/pqdo_chan_if.sv
rtl/core/pqdo_ram.sv
rtl/core/pqdo_select.sv
rtl/core/priority_queue_drop_oldest.sv
rtl/core/pqdo_checker.sv
test/priority_queue_drop_oldest_tb.sv
